@@ design/pcwr_pkg.sv @@
// Shared constants, types and register codes for the profile column window range block.
package pcwr_pkg;

	// Geometry
	localparam int NUM_COLUMNS = 400;
	localparam int WINDOW      = 20;

	// Field widths
	localparam int COL_W  = 9;
	localparam int X_W    = 17;
	localparam int Z_W    = 21;
	localparam int OFS_W  = 17;
	localparam int COS_W  = 15;
	localparam int SIN_W  = 16;
	localparam int PIT_W  = 17;
	localparam int CX_W   = 19;
	localparam int RNG_W  = 17;
	localparam int SV_W   = 18;
	localparam int SLOT_W = 5;
	localparam int FCNT_W = 6;

	// Stream and config port widths
	localparam int IN_W       = 48;
	localparam int OUT_W      = 48;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_W      = 17;

	// Arithmetic widths
	localparam int ZS_W  = Z_W + 1;
	localparam int PX_W  = X_W + SIN_W;
	localparam int PZ_W  = ZS_W + SIN_W;
	localparam int SUM_W = PZ_W + 1;
	localparam int RND_W = SUM_W - 15;
	localparam int XP_W  = RND_W + 1;

	// Window store: one row of WINDOW entries per column
	localparam int ROW_W  = WINDOW * SV_W;
	localparam int ADDR_W = $clog2(NUM_COLUMNS);
	localparam int LANES  = 4;
	localparam int GROUPS = (WINDOW + LANES - 1) / LANES;
	localparam int GRP_W  = $clog2(GROUPS) + 1;
	localparam int SCAN_W = GROUPS * LANES * SV_W;

	// Front queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// Limits
	localparam int Z_INVALID_BELOW = -50000;
	localparam int RANGE_LIMIT     = 50000;
	localparam int STORE_FILL      = 131071;
	localparam int X_SAT           = 200000;
	localparam int ROUND_HALF      = 16384;

	// Config register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_Z_OFFSET = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ROT_COS  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ROT_SIN  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PIT      = 2'd3;

	// Classified input item
	typedef struct packed {
		logic [COL_W-1:0]        col;
		logic signed [X_W-1:0]   x;
		logic signed [Z_W-1:0]   z;
		logic                    valid;
		logic                    in_range;
		logic                    last;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	// Back end to front end control
	typedef struct packed {
		logic pop;
		logic clearing;
	} ctl_t;

	// Configuration registers
	typedef struct packed {
		logic signed [OFS_W-1:0] z_offset;
		logic [COS_W-1:0]        rot_cos;
		logic signed [SIN_W-1:0] rot_sin;
		logic signed [PIT_W-1:0] pit_shift;
	} cfg_t;

	// One result
	typedef struct packed {
		logic [COL_W-1:0]       col;
		logic                   sample_valid;
		logic signed [CX_W-1:0] corrected_x;
		logic                   range_valid;
		logic [RNG_W-1:0]       range_um;
	} res_t;

endpackage

@@ design/profile_column_window_range.sv @@
// Top level of the per-column laser profile window range tracker.
//
//  channel  direction  handshake           payload
//  s        in         s_tvalid/s_tready   s_tdata: column, raw_x_um, raw_z_um
//  m        out        m_tvalid/m_tready   m_tdata: out_column, sample_valid,
//                                          corrected_x_um, range_valid, range_um
//  cfg      in         cfg_we              cfg_addr, cfg_wdata
//
// Each request runs idle, multiply, sum, store read-modify-write, scan and output;
// the store step is only for a valid in-range sample, and the scan only once more
// than WINDOW frames have closed (the store row is scanned four entries a cycle).
// One request is worked at a time. After reset the store is swept to its fill value,
// one row a cycle, during which s_tready is low. A four-deep queue keeps taking
// requests, until it is full, while the result register waits on m_tready.
module profile_column_window_range (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [8:0] column, [25:9] raw_x_um, [46:26] raw_z_um, [47] zero
	input  logic [pcwr_pkg::IN_W-1:0]        s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [8:0] out_column, [9] sample_valid, [28:10] corrected_x_um,
	// [29] range_valid, [46:30] range_um, [47] zero
	output logic [pcwr_pkg::OUT_W-1:0]       m_tdata,
	input  logic                             cfg_we,
	input  logic [pcwr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pcwr_pkg::CFG_W-1:0]       cfg_wdata
);

	pcwr_pkg::cfg_t  cfg_q;
	pcwr_pkg::head_t head;
	pcwr_pkg::ctl_t  ctl;
	pcwr_pkg::res_t  res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.z_offset  <= '0;
			cfg_q.rot_cos   <= pcwr_pkg::COS_W'(32767);
			cfg_q.rot_sin   <= '0;
			cfg_q.pit_shift <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				pcwr_pkg::REG_Z_OFFSET: cfg_q.z_offset  <= cfg_wdata[pcwr_pkg::OFS_W-1:0];
				pcwr_pkg::REG_ROT_COS:  cfg_q.rot_cos   <= cfg_wdata[pcwr_pkg::COS_W-1:0];
				pcwr_pkg::REG_ROT_SIN:  cfg_q.rot_sin   <= cfg_wdata[pcwr_pkg::SIN_W-1:0];
				pcwr_pkg::REG_PIT:      cfg_q.pit_shift <= cfg_wdata[pcwr_pkg::PIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pcwr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.ctl     (ctl),
		.head    (head)
	);

	pcwr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.ctl      (ctl),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	// result packing, first field lowest
	assign m_tdata = {1'b0, res.range_um, res.range_valid, res.corrected_x,
		res.sample_valid, res.col};

endmodule

@@ design/pcwr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcwr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/pcwr_front.sv @@
// Front end: accepts input requests, classifies them and queues them for the back end.
module pcwr_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [pcwr_pkg::IN_W-1:0] s_tdata,
	input  pcwr_pkg::ctl_t          ctl,
	output pcwr_pkg::head_t         head
);

	pcwr_pkg::item_t                  item_in;
	pcwr_pkg::item_t                  q_mem_q [pcwr_pkg::QDEPTH];
	logic [pcwr_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [pcwr_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [pcwr_pkg::QCNT_W-1:0]      cnt_q;
	logic                             push;
	logic [pcwr_pkg::COL_W+1:0]       col_wide;

	// unpack and classify
	assign col_wide         = {2'b00, s_tdata[8:0]};
	assign item_in.col      = s_tdata[8:0];
	assign item_in.x        = s_tdata[25:9];
	assign item_in.z        = s_tdata[46:26];
	assign item_in.valid    = item_in.z >= pcwr_pkg::Z_W'(pcwr_pkg::Z_INVALID_BELOW);
	assign item_in.in_range = col_wide < (pcwr_pkg::COL_W + 2)'(pcwr_pkg::NUM_COLUMNS);
	assign item_in.last     = col_wide == (pcwr_pkg::COL_W + 2)'(pcwr_pkg::NUM_COLUMNS - 1);

	// no request taken while the store clear runs
	assign s_tready = (cnt_q != pcwr_pkg::QCNT_W'(pcwr_pkg::QDEPTH)) && !ctl.clearing;
	assign push     = s_tvalid && s_tready;

	assign head.valid = cnt_q != '0;
	assign head.item  = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, ctl.pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/pcwr_back.sv @@
// Back end: rotation, window store update, min/max scan and result register.
module pcwr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pcwr_pkg::cfg_t   cfg,
	input  pcwr_pkg::head_t  head,
	output pcwr_pkg::ctl_t   ctl,
	output logic             res_valid,
	input  logic             res_ready,
	output pcwr_pkg::res_t   res
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_SCAN = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]                          state_q;
	logic [pcwr_pkg::ADDR_W-1:0]         clr_q;
	pcwr_pkg::item_t                     item_q;
	logic [pcwr_pkg::FCNT_W-1:0]         frame_cnt_q;
	logic [pcwr_pkg::SLOT_W-1:0]         slot_q;

	logic signed [pcwr_pkg::ZS_W-1:0]    zs;
	logic signed [pcwr_pkg::SIN_W-1:0]   cos_s;
	logic signed [pcwr_pkg::PX_W-1:0]    xc_q;
	logic signed [pcwr_pkg::PX_W-1:0]    xs_q;
	logic signed [pcwr_pkg::PZ_W-1:0]    zsn_q;
	logic signed [pcwr_pkg::PZ_W-1:0]    zc_q;

	logic signed [pcwr_pkg::SUM_W-1:0]   xsum;
	logic signed [pcwr_pkg::SUM_W-1:0]   zsum;
	logic signed [pcwr_pkg::RND_W-1:0]   xr;
	logic signed [pcwr_pkg::RND_W-1:0]   zr;
	logic signed [pcwr_pkg::XP_W-1:0]    xp;
	logic signed [pcwr_pkg::CX_W-1:0]    cx_sat;
	logic signed [pcwr_pkg::SV_W-1:0]    zr_sat;
	logic signed [pcwr_pkg::CX_W-1:0]    cx_q;
	logic signed [pcwr_pkg::SV_W-1:0]    zr_q;

	logic                                ram_we;
	logic [pcwr_pkg::ADDR_W-1:0]         ram_waddr;
	logic [pcwr_pkg::ROW_W-1:0]          ram_wdata;
	logic                                ram_re;
	logic [pcwr_pkg::ROW_W-1:0]          ram_rdata;
	logic [pcwr_pkg::ROW_W-1:0]          merged;
	logic [pcwr_pkg::ROW_W-1:0]          fill_row;

	logic [pcwr_pkg::SCAN_W-1:0]         row_q;
	logic [pcwr_pkg::GRP_W-1:0]          grp_q;
	logic signed [pcwr_pkg::SV_W-1:0]    mn_q;
	logic signed [pcwr_pkg::SV_W-1:0]    mx_q;
	logic signed [pcwr_pkg::SV_W-1:0]    mn_d;
	logic signed [pcwr_pkg::SV_W-1:0]    mx_d;
	logic signed [pcwr_pkg::SV_W-1:0]    elem;
	logic                                rng_en_q;
	logic                                rng_ok;
	logic signed [pcwr_pkg::SV_W:0]      diff;

	logic                                out_free;
	logic                                load;
	logic                                res_valid_q;
	pcwr_pkg::res_t                      res_q;

	assign fill_row = {pcwr_pkg::WINDOW{pcwr_pkg::SV_W'(pcwr_pkg::STORE_FILL)}};

	// stage 1: products of the rotation
	assign zs    = pcwr_pkg::ZS_W'(item_q.z) - pcwr_pkg::ZS_W'(cfg.z_offset);
	assign cos_s = $signed({1'b0, cfg.rot_cos});

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			xc_q  <= pcwr_pkg::PX_W'(item_q.x) * pcwr_pkg::PX_W'(cos_s);
			xs_q  <= pcwr_pkg::PX_W'(item_q.x) * pcwr_pkg::PX_W'(cfg.rot_sin);
			zsn_q <= pcwr_pkg::PZ_W'(zs) * pcwr_pkg::PZ_W'(cfg.rot_sin);
			zc_q  <= pcwr_pkg::PZ_W'(zs) * pcwr_pkg::PZ_W'(cos_s);
		end
	end

	// stage 2: sums, round half up, pit shift, saturation
	assign xsum = pcwr_pkg::SUM_W'(xc_q) + pcwr_pkg::SUM_W'(zsn_q)
		+ pcwr_pkg::SUM_W'(pcwr_pkg::ROUND_HALF);
	assign zsum = pcwr_pkg::SUM_W'(zc_q) - pcwr_pkg::SUM_W'(xs_q)
		+ pcwr_pkg::SUM_W'(pcwr_pkg::ROUND_HALF);
	assign xr   = xsum[pcwr_pkg::SUM_W-1:15];
	assign zr   = zsum[pcwr_pkg::SUM_W-1:15];
	assign xp   = pcwr_pkg::XP_W'(xr) - pcwr_pkg::XP_W'(cfg.pit_shift);

	always_comb begin
		if (xp > pcwr_pkg::XP_W'(pcwr_pkg::X_SAT)) begin
			cx_sat = pcwr_pkg::CX_W'(pcwr_pkg::X_SAT);
		end else if (xp < pcwr_pkg::XP_W'(-pcwr_pkg::X_SAT)) begin
			cx_sat = pcwr_pkg::CX_W'(-pcwr_pkg::X_SAT);
		end else begin
			cx_sat = xp[pcwr_pkg::CX_W-1:0];
		end
		if (zr > pcwr_pkg::RND_W'(pcwr_pkg::STORE_FILL)) begin
			zr_sat = pcwr_pkg::SV_W'(pcwr_pkg::STORE_FILL);
		end else if (zr < pcwr_pkg::RND_W'(-pcwr_pkg::STORE_FILL)) begin
			zr_sat = pcwr_pkg::SV_W'(-pcwr_pkg::STORE_FILL);
		end else begin
			zr_sat = zr[pcwr_pkg::SV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			cx_q <= item_q.valid ? cx_sat : '0;
			zr_q <= zr_sat;
		end
	end

	// new value goes into the current ring slot of the row
	always_comb begin
		merged = ram_rdata;
		merged[int'(slot_q) * pcwr_pkg::SV_W +: pcwr_pkg::SV_W] = zr_q;
	end

	// store ports: clear sweep after reset, then read-modify-write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = item_q.col[pcwr_pkg::ADDR_W-1:0];
		ram_wdata = merged;
		if (state_q == ST_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = fill_row;
		end else if (state_q == ST_RD) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == ST_SUM) && item_q.valid && item_q.in_range;

	pcwr_ram #(
		.WIDTH(pcwr_pkg::ROW_W),
		.DEPTH(pcwr_pkg::NUM_COLUMNS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(item_q.col[pcwr_pkg::ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// min/max over LANES entries per cycle, skipping pad lanes
	always_comb begin
		mn_d = mn_q;
		mx_d = mx_q;
		elem = '0;
		for (int l = 0; l < pcwr_pkg::LANES; l++) begin
			elem = row_q[l * pcwr_pkg::SV_W +: pcwr_pkg::SV_W];
			if (int'(grp_q) * pcwr_pkg::LANES + l < pcwr_pkg::WINDOW) begin
				if (elem < mn_d) begin
					mn_d = elem;
				end
				if (elem > mx_d) begin
					mx_d = elem;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			row_q <= pcwr_pkg::SCAN_W'(merged);
			grp_q <= '0;
			mn_q  <= pcwr_pkg::SV_W'(pcwr_pkg::STORE_FILL);
			mx_q  <= pcwr_pkg::SV_W'(-pcwr_pkg::STORE_FILL - 1);
		end else if (state_q == ST_SCAN) begin
			row_q <= row_q >> (pcwr_pkg::LANES * pcwr_pkg::SV_W);
			grp_q <= grp_q + 1'b1;
			mn_q  <= mn_d;
			mx_q  <= mx_d;
		end
	end

	// range result
	assign rng_ok = rng_en_q && (mx_q < pcwr_pkg::SV_W'(pcwr_pkg::RANGE_LIMIT))
		&& (mn_q > pcwr_pkg::SV_W'(-pcwr_pkg::RANGE_LIMIT));
	assign diff   = (pcwr_pkg::SV_W + 1)'(mx_q) - (pcwr_pkg::SV_W + 1)'(mn_q);

	// output register
	assign out_free = !res_valid_q || res_ready;
	assign load     = (state_q == ST_OUT) && out_free;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.col          <= item_q.col;
			res_q.sample_valid <= item_q.valid;
			res_q.corrected_x  <= cx_q;
			res_q.range_valid  <= rng_ok;
			res_q.range_um     <= rng_ok ? diff[pcwr_pkg::RNG_W-1:0] : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign ctl.pop      = (state_q == ST_IDLE) && head.valid;
	assign ctl.clearing = state_q == ST_CLR;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			item_q <= head.item;
		end
	end

	// sequencer, frame counters, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			frame_cnt_q <= '0;
			slot_q      <= '0;
			rng_en_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == pcwr_pkg::ADDR_W'(pcwr_pkg::NUM_COLUMNS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rng_en_q <= 1'b0;
					if (head.valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= (item_q.valid && item_q.in_range) ? ST_RD : ST_OUT;
				end
				ST_RD: begin
					if (frame_cnt_q > pcwr_pkg::FCNT_W'(pcwr_pkg::WINDOW)) begin
						rng_en_q <= 1'b1;
						state_q  <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					if (grp_q == pcwr_pkg::GRP_W'(pcwr_pkg::GROUPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (item_q.last) begin
							if (frame_cnt_q < pcwr_pkg::FCNT_W'(pcwr_pkg::WINDOW + 1)) begin
								frame_cnt_q <= frame_cnt_q + 1'b1;
							end
							if (slot_q == pcwr_pkg::SLOT_W'(pcwr_pkg::WINDOW - 1)) begin
								slot_q <= '0;
							end else begin
								slot_q <= slot_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/pcwr_checker.sv @@
// Port-level checks on the result stream of the window range tracker.
module pcwr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pcwr_pkg::OUT_W-1:0]  m_tdata
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// an invalid sample gives zero x and no range
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[9] |-> (m_tdata[47:10] == 38'd0))
		else $error("invalid sample carries nonzero fields");

	// no range value without its valid flag
	a_range_gated: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[29] |-> (m_tdata[46:30] == 17'd0))
		else $error("range nonzero while flagged invalid");

	// a valid range lies inside the two-sided limit
	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> (m_tdata[46:30] < 17'(2 * pcwr_pkg::RANGE_LIMIT)))
		else $error("range exceeds window limit");

endmodule

bind profile_column_window_range pcwr_checker u_pcwr_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the per-column laser profile window range tracker.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 600000;

	// One result as it leaves the block
	typedef struct packed {
		logic [pcwr_pkg::COL_W-1:0]       column;
		logic                             sample_valid;
		logic signed [pcwr_pkg::CX_W-1:0] corrected_x;
		logic                             range_valid;
		logic [pcwr_pkg::RNG_W-1:0]       range_um;
	} column_result_t;

	// Directed sample; typed rows carry their own expected result
	typedef struct packed {
		logic [pcwr_pkg::COL_W-1:0]       col;
		logic signed [pcwr_pkg::X_W-1:0]  x;
		logic signed [pcwr_pkg::Z_W-1:0]  z;
		logic                             typed;
		column_result_t                   want;
	} probe_row_t;

	localparam probe_row_t PROBES [16] = '{
		'{9'd0,   17'sd0,       21'sd0,        1'b1, '{9'd0, 1'b1, 19'sd0, 1'b0, 17'd0}},
		'{9'd1,   17'sd50000,   21'sd1000000,  1'b0, '0},
		'{9'd2,   -17'sd50000,  -21'sd1000000, 1'b1, '{9'd2, 1'b0, 19'sd0, 1'b0, 17'd0}},
		'{9'd3,   17'sd65535,   -21'sd50000,   1'b0, '0},
		'{9'd4,   -17'sd65536,  -21'sd50001,   1'b1, '{9'd4, 1'b0, 19'sd0, 1'b0, 17'd0}},
		'{9'd5,   17'sd12345,   21'sd1048575,  1'b0, '0},
		'{9'd6,   17'sd0,       -21'sd1048576, 1'b1, '{9'd6, 1'b0, 19'sd0, 1'b0, 17'd0}},
		'{9'd400, 17'sd1000,    21'sd2000,     1'b0, '0},
		'{9'd511, -17'sd65536,  21'sd0,        1'b0, '0},
		'{9'd511, 17'sd5,       -21'sd60000,   1'b1, '{9'd511, 1'b0, 19'sd0, 1'b0, 17'd0}},
		'{9'd399, 17'sd0,       21'sd0,        1'b0, '0},
		'{9'd399, -17'sd7,      -21'sd50001,   1'b1, '{9'd399, 1'b0, 19'sd0, 1'b0, 17'd0}},
		'{9'd398, 17'sd0,       21'sd0,        1'b1, '{9'd398, 1'b1, 19'sd0, 1'b0, 17'd0}},
		'{9'd0,   -17'sd50000,  21'sd50000,    1'b0, '0},
		'{9'd7,   17'sh0AAAA,   21'sh0AAAAA,   1'b0, '0},
		'{9'd8,   17'sh15555,   21'sh055555,   1'b0, '0}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [pcwr_pkg::IN_W-1:0]       s_tdata;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [pcwr_pkg::OUT_W-1:0]      m_tdata;
	logic                            cfg_we;
	logic [pcwr_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [pcwr_pkg::CFG_W-1:0]      cfg_wdata;

	// Predictor copy of the registers and the column rings
	logic signed [pcwr_pkg::OFS_W-1:0] cfg_z_offset = '0;
	logic [pcwr_pkg::COS_W-1:0]        cfg_cos = 15'd32767;
	logic signed [pcwr_pkg::SIN_W-1:0] cfg_sin = '0;
	logic signed [pcwr_pkg::PIT_W-1:0] cfg_pit = '0;
	logic signed [pcwr_pkg::SV_W-1:0]  height_ring [pcwr_pkg::NUM_COLUMNS*pcwr_pkg::WINDOW];
	int                                frames_seen = 0;
	int                                ring_pos = 0;

	column_result_t pending_results [$];
	int             mismatches = 0;
	int             samples_sent = 0;
	int             cycle_count = 0;
	bit             steady = 1'b0;

	profile_column_window_range dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver stalls, none while steady
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 25);
	end

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Rotate one sample, update its column ring and frame position
	function automatic column_result_t track_column_sample(logic [pcwr_pkg::COL_W-1:0] col,
			logic signed [pcwr_pkg::X_W-1:0] x, logic signed [pcwr_pkg::Z_W-1:0] z);
		column_result_t r;
		longint zs, xr, zr, lo_v, hi_v, e;
		int base;
		r = '0;
		r.column = col;
		if (longint'(z) >= pcwr_pkg::Z_INVALID_BELOW) begin
			zs = longint'(z) - longint'(cfg_z_offset);
			xr = (longint'(x) * longint'(cfg_cos) + zs * longint'(cfg_sin)
				+ pcwr_pkg::ROUND_HALF) >>> 15;
			zr = (zs * longint'(cfg_cos) - longint'(x) * longint'(cfg_sin)
				+ pcwr_pkg::ROUND_HALF) >>> 15;
			xr = clamp_sym(xr - longint'(cfg_pit), pcwr_pkg::X_SAT);
			zr = clamp_sym(zr, pcwr_pkg::STORE_FILL);
			r.sample_valid = 1'b1;
			r.corrected_x = xr[pcwr_pkg::CX_W-1:0];
			if (col < pcwr_pkg::NUM_COLUMNS) begin
				base = int'(col) * pcwr_pkg::WINDOW;
				height_ring[base + ring_pos] = zr[pcwr_pkg::SV_W-1:0];
				if (frames_seen > pcwr_pkg::WINDOW) begin
					lo_v = height_ring[base];
					hi_v = height_ring[base];
					for (int k = 1; k < pcwr_pkg::WINDOW; k++) begin
						e = height_ring[base + k];
						if (e < lo_v) lo_v = e;
						if (e > hi_v) hi_v = e;
					end
					if (hi_v < pcwr_pkg::RANGE_LIMIT && lo_v > -pcwr_pkg::RANGE_LIMIT) begin
						r.range_valid = 1'b1;
						r.range_um = pcwr_pkg::RNG_W'(hi_v - lo_v);
					end
				end
			end
		end
		// last column closes the frame, valid or not
		if (col == pcwr_pkg::NUM_COLUMNS - 1) begin
			if (frames_seen < pcwr_pkg::WINDOW + 1) frames_seen++;
			ring_pos = (ring_pos + 1) % pcwr_pkg::WINDOW;
		end
		return r;
	endfunction

	task automatic check_field(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : watch_results
		column_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result for column %0d with no request outstanding", m_tdata[8:0]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("out_column", want.column, m_tdata[8:0]);
				check_field("sample_valid", want.sample_valid, m_tdata[9]);
				check_field("corrected_x_um", longint'(want.corrected_x),
					longint'($signed(m_tdata[28:10])));
				check_field("range_valid", want.range_valid, m_tdata[29]);
				check_field("range_um", want.range_um, m_tdata[46:30]);
			end
		end
	end

	// Present one request; log its expectation once it is taken
	task automatic offer_sample(logic [pcwr_pkg::COL_W-1:0] col,
			logic signed [pcwr_pkg::X_W-1:0] x, logic signed [pcwr_pkg::Z_W-1:0] z,
			logic typed, column_result_t want);
		column_result_t predicted;
		if (!steady) begin
			while ($urandom_range(99) < 25) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, z, x, col};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = track_column_sample(col, x, z);
		pending_results.push_back(typed ? want : predicted);
		samples_sent++;
	endtask

	// Valid sample with rotated height kept well inside the range window
	task automatic send_shaped(int col);
		int lo, zs, xv, zv;
		lo = -50000 - int'(cfg_z_offset);
		if (lo < -20000) lo = -20000;
		zs = lo + int'($urandom_range(20000 - lo));
		xv = int'($urandom_range(40000)) - 20000;
		zv = zs + int'(cfg_z_offset);
		offer_sample(col[pcwr_pkg::COL_W-1:0], xv[pcwr_pkg::X_W-1:0], zv[pcwr_pkg::Z_W-1:0],
			1'b0, '0);
	endtask

	task automatic write_register(logic [pcwr_pkg::CFG_ADDR_W-1:0] idx, int val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[pcwr_pkg::CFG_W-1:0];
		@(posedge clk);
		case (idx)
			pcwr_pkg::REG_Z_OFFSET: cfg_z_offset = val[pcwr_pkg::OFS_W-1:0];
			pcwr_pkg::REG_ROT_COS:  cfg_cos = val[pcwr_pkg::COS_W-1:0];
			pcwr_pkg::REG_ROT_SIN:  cfg_sin = val[pcwr_pkg::SIN_W-1:0];
			pcwr_pkg::REG_PIT:      cfg_pit = val[pcwr_pkg::PIT_W-1:0];
			default: ;
		endcase
	endtask

	// Idle the request side and let every result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int zv, cv, sv, pv, nact, quota, r;
		int active [8];
		logic [31:0] rc, rx, rz;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		foreach (height_ring[i]) height_ring[i] = pcwr_pkg::SV_W'(pcwr_pkg::STORE_FILL);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed samples under the reset settings
		foreach (PROBES[i])
			offer_sample(PROBES[i].col, PROBES[i].x, PROBES[i].z, PROBES[i].typed, PROBES[i].want);

		// Phases of random frames, each under its own register settings
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			steady = (p == 3);
			if (p == 1) begin
				zv = -50000; cv = 0; sv = -32768; pv = 50000;
			end else if (p == 2) begin
				zv = 50000; cv = 32767; sv = 32767; pv = -50000;
			end else if (p == 3) begin
				zv = 0; cv = 32767; sv = 0; pv = 0;
			end else begin
				zv = int'($urandom_range(100000)) - 50000;
				cv = int'($urandom_range(32767));
				sv = int'($urandom_range(65535)) - 32768;
				pv = int'($urandom_range(100000)) - 50000;
			end
			if (p > 0) begin
				write_register(pcwr_pkg::REG_Z_OFFSET, zv);
				write_register(pcwr_pkg::REG_ROT_COS, cv);
				write_register(pcwr_pkg::REG_ROT_SIN, sv);
				write_register(pcwr_pkg::REG_PIT, pv);
				cfg_we <= 1'b0;
			end

			// a few columns tracked frame after frame
			nact = int'($urandom_range(7, 3));
			for (int k = 0; k < nact; k++)
				active[k] = int'($urandom_range(pcwr_pkg::NUM_COLUMNS - 2));
			if (p == 2) active[0] = 0;
			if (p == 4) active[0] = pcwr_pkg::NUM_COLUMNS - 2;

			quota = samples_sent + 230;
			while (samples_sent < quota) begin
				for (int k = 0; k < nact; k++) begin
					r = int'($urandom_range(99));
					if (r < 10) begin
						// noise over the full field widths
						rc = $urandom;
						rx = $urandom;
						rz = $urandom;
						offer_sample(rc[pcwr_pkg::COL_W-1:0], rx[pcwr_pkg::X_W-1:0],
							rz[pcwr_pkg::Z_W-1:0], 1'b0, '0);
					end else if (r >= 15) begin
						send_shaped(active[k]);
					end
				end
				send_shaped(pcwr_pkg::NUM_COLUMNS - 1);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ profile_column_window_range.f @@
design/pcwr_pkg.sv
design/pcwr_ram.sv
design/pcwr_front.sv
design/pcwr_back.sv
design/profile_column_window_range.sv
design/pcwr_checker.sv
sim/tb.sv
